### hw/rtl/toyvm_pkg.sv
`default_nettype none

package toyvm_pkg;

    localparam int NUM_REGS    = 16;
    localparam int STACK_DEPTH = 16;
    localparam int PC_BITS     = 16;

    localparam int REG_IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam int SP_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W   = $clog2(STACK_DEPTH + 1);

    localparam int IN_W  = 32;
    localparam int OUT_W = 64;

    typedef enum logic [4:0] {
        OP_MOV = 5'd0,
        OP_ADD = 5'd1,
        OP_SUB = 5'd2,
        OP_JMP = 5'd3,
        OP_CAL = 5'd4,
        OP_RET = 5'd5,
        OP_CMP = 5'd6
    } t_op;

    typedef enum logic [2:0] {
        CC_NONE = 3'd0,
        CC_EQ   = 3'd1,
        CC_LT   = 3'd2,
        CC_GT   = 3'd3,
        CC_LE   = 3'd4,
        CC_GE   = 3'd5
    } t_cc;

    typedef enum logic [1:0] {
        MODE_REG    = 2'd0,
        MODE_OP2IMM = 2'd1,
        MODE_OP1IMM = 2'd2,
        MODE_BOTH   = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_DONE = 2'd0,
        ST_SKIP = 2'd1,
        ST_BAD  = 2'd2,
        ST_OVF  = 2'd3
    } t_status;

endpackage

`default_nettype wire

### hw/rtl/toy_vm_instruction_executor_unit.sv
// Channel  Direction  Handshake                  Payload
// s_axis   in         s_axis_tvalid/tready       tdata: func, flag_bits, operand_field
// m_axis   out        m_axis_tvalid/tready       tdata: next_pc .. halted
// cfg      in         i_cfg_we                   i_cfg_wdata: program_end
//
// One instruction per clock while the output is not stalled: a beat sits in the input
// register while its register operands are read, then executes into the output register.
// Reset clears the register valid bits, so registers read as zero, and the compare code
// and call depth, sets the counter to one and sets program_end to 0xFFFF.
// A stalled output holds execution; the input register keeps accepting while
// the output register is free or is being drained.
`default_nettype none

module toy_vm_instruction_executor_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic [15:0] i_cfg_wdata,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // [4:0] func, [9:5] flag_bits, [31:10] operand_field
    input  wire logic [toyvm_pkg::IN_W-1:0]  s_axis_tdata,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // [15:0] next_pc, [17:16] status, [20:18] compare_code, [21] write_valid,
    // [25:22] write_index, [57:26] write_value, [58] halted, [63:59] zero
    output logic [toyvm_pkg::OUT_W-1:0] m_axis_tdata
);
    import toyvm_pkg::*;

    logic [31:0]        r_regs [NUM_REGS];
    logic [NUM_REGS-1:0] r_reg_vld;
    logic [PC_BITS-1:0] r_stack [STACK_DEPTH];
    logic [DEPTH_W-1:0] r_depth;
    logic [2:0]         r_cmp;
    logic [PC_BITS-1:0] r_pc;
    logic [15:0]        r_end;

    logic        r_in_vld;
    logic [4:0]  r_func;
    logic [4:0]  r_flag;
    logic [21:0] r_field;
    logic [31:0] r_rda;
    logic [31:0] r_rdb;

    logic                r_out_vld;
    logic [OUT_W-1:0]    r_out;

    logic                advance;
    logic                accept;
    logic                exec;

    logic [9:0]          s_op1;
    logic [9:0]          s_op2;
    logic [9:0]          op1;
    logic [9:0]          op2;
    logic [2:0]          cond;
    t_mode               mode;
    logic                hit;
    logic                halted_now;

    logic [PC_BITS-1:0]  n_pc;
    logic [2:0]          n_cmp;
    logic [DEPTH_W-1:0]  n_depth;
    t_status             n_status;
    logic                wr_en;
    logic [REG_IDX_W-1:0] wr_idx;
    logic [31:0]         wr_val;
    logic                push;
    logic [PC_BITS-1:0]  push_val;
    logic [PC_BITS-1:0]  pc_inc;
    logic [PC_BITS-1:0]  pop_val;
    logic [31:0]         alu_b;
    logic signed [32:0]  cmp_a;
    logic signed [32:0]  cmp_b;
    logic                n_halt;

    assign advance       = !r_out_vld || m_axis_tready;
    assign exec          = r_in_vld && advance;
    assign s_axis_tready = !r_in_vld || advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign s_op1 = s_axis_tdata[19:10];
    assign s_op2 = s_axis_tdata[30:21];

    assign op1  = r_field[9:0];
    assign op2  = r_field[20:11];
    assign cond = r_flag[2:0];
    assign mode = t_mode'(r_flag[4:3]);

    assign pc_inc     = r_pc + PC_BITS'(1);
    assign pop_val    = r_stack[SP_W'(r_depth - DEPTH_W'(1))];
    assign halted_now = 32'(r_pc) >= 32'(r_end);

    always_comb begin
        hit = 1'b0;
        if (cond != CC_NONE) begin
            hit = (cond == r_cmp)
               || (cond == CC_LE && (r_cmp inside {CC_EQ, CC_LT}))
               || (cond == CC_GE && (r_cmp inside {CC_EQ, CC_GT}));
        end
    end

    always_comb begin
        n_pc     = r_pc;
        n_cmp    = r_cmp;
        n_depth  = r_depth;
        n_status = ST_DONE;
        wr_en    = 1'b0;
        wr_idx   = op1[REG_IDX_W-1:0];
        wr_val   = 32'd0;
        push     = 1'b0;
        push_val = pc_inc;
        alu_b    = (mode == MODE_OP2IMM) ? {22'd0, op2} : r_rdb;
        cmp_a    = (mode == MODE_OP1IMM) ? $signed({23'd0, op1})
                                         : $signed({r_rda[31], r_rda});
        cmp_b    = (mode == MODE_OP2IMM) ? $signed({23'd0, op2})
                                         : $signed({r_rdb[31], r_rdb});
        if (halted_now) begin
            n_status = ST_SKIP;
        end else if (r_func != OP_RET && r_func <= OP_CMP && hit) begin
            n_pc     = pc_inc;
            n_status = ST_SKIP;
        end else begin
            case (t_op'(r_func))
                OP_MOV, OP_ADD, OP_SUB: begin
                    case (t_op'(r_func))
                        OP_MOV:  wr_val = alu_b;
                        OP_ADD:  wr_val = r_rda + alu_b;
                        default: wr_val = r_rda - alu_b;
                    endcase
                    wr_en = {1'b0, op1} < 11'(NUM_REGS);
                    n_pc  = pc_inc;
                end
                OP_JMP, OP_CAL: begin
                    if (r_func == OP_CAL && 32'(r_depth) >= 32'(STACK_DEPTH)) begin
                        n_pc     = pc_inc;
                        n_status = ST_OVF;
                    end else begin
                        if (r_func == OP_CAL) begin
                            push    = 1'b1;
                            n_depth = r_depth + DEPTH_W'(1);
                        end
                        if (mode == MODE_OP2IMM) begin
                            n_pc = r_pc + PC_BITS'(r_field);
                        end else begin
                            n_pc = r_pc - PC_BITS'(r_field);
                        end
                    end
                end
                OP_RET: begin
                    if (r_depth == '0) begin
                        n_pc     = pc_inc;
                        n_status = ST_SKIP;
                    end else begin
                        n_depth = r_depth - DEPTH_W'(1);
                        n_pc    = pop_val;
                    end
                end
                OP_CMP: begin
                    n_cmp = (cmp_a == cmp_b) ? CC_EQ : (cmp_a < cmp_b) ? CC_LT : CC_GT;
                    n_pc  = pc_inc;
                end
                default: begin
                    n_pc     = pc_inc;
                    n_status = ST_BAD;
                end
            endcase
        end
        if (!wr_en) begin
            wr_val = 32'd0;
        end
        n_halt = 32'(n_pc) >= 32'(r_end);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_reg_vld <= '0;
            r_depth   <= '0;
            r_cmp     <= CC_NONE;
            r_pc      <= PC_BITS'(1);
            r_end     <= 16'hFFFF;
        end else begin
            if (i_cfg_we) begin
                r_end <= i_cfg_wdata;
            end
            if (s_axis_tready) begin
                r_in_vld <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_vld <= r_in_vld;
            end
            if (exec) begin
                r_pc    <= n_pc;
                r_cmp   <= n_cmp;
                r_depth <= n_depth;
                if (wr_en) begin
                    r_reg_vld[wr_idx] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (exec && wr_en) begin
            r_regs[wr_idx] <= wr_val;
        end
        if (exec && push) begin
            r_stack[r_depth[SP_W-1:0]] <= push_val;
        end
        if (accept) begin
            r_func  <= s_axis_tdata[4:0];
            r_flag  <= s_axis_tdata[9:5];
            r_field <= s_axis_tdata[31:10];
            if ({1'b0, s_op1} >= 11'(NUM_REGS)) begin
                r_rda <= 32'd0;
            end else if (exec && wr_en && wr_idx == s_op1[REG_IDX_W-1:0]) begin
                r_rda <= wr_val;
            end else if (r_reg_vld[s_op1[REG_IDX_W-1:0]]) begin
                r_rda <= r_regs[s_op1[REG_IDX_W-1:0]];
            end else begin
                r_rda <= 32'd0;
            end
            if ({1'b0, s_op2} >= 11'(NUM_REGS)) begin
                r_rdb <= 32'd0;
            end else if (exec && wr_en && wr_idx == s_op2[REG_IDX_W-1:0]) begin
                r_rdb <= wr_val;
            end else if (r_reg_vld[s_op2[REG_IDX_W-1:0]]) begin
                r_rdb <= r_regs[s_op2[REG_IDX_W-1:0]];
            end else begin
                r_rdb <= 32'd0;
            end
        end
        if (exec) begin
            r_out <= {5'd0, n_halt, wr_val, 4'(wr_en ? op1[3:0] : 4'd0), wr_en,
                      n_cmp, n_status, 16'(n_pc)};
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out;

    a_depth_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_depth) <= 32'(STACK_DEPTH))
        else $error("call depth beyond stack size");

    a_ovf_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[17:16] == ST_OVF) |->
            32'(r_depth) == 32'(STACK_DEPTH))
        else $error("overflow reported with room on the stack");

    a_no_write_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[21]) |-> m_axis_tdata[57:22] == '0)
        else $error("write fields set without a register write");

    a_halt_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (exec && halted_now) |=> (r_pc == $past(r_pc) && r_depth == $past(r_depth)))
        else $error("state changed while halted");

    a_exec_fills_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        exec |=> m_axis_tvalid)
        else $error("executed beat did not reach the output");

endmodule

`default_nettype wire

### test/toy_vm_instruction_executor_unit_tb.sv
`timescale 1ns / 100ps

module toy_vm_instruction_executor_unit_tb;
    import toyvm_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam logic [4:0] OP_UNKNOWN_LO = 5'd7;
    localparam logic [4:0] OP_UNKNOWN_HI = 5'd31;

    typedef struct packed {
        logic [15:0] next_pc;
        t_status     status;
        logic [2:0]  compare_code;
        logic        write_valid;
        logic [3:0]  write_index;
        logic [31:0] write_value;
        logic        halted;
    } t_vm_result;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic [15:0]       i_cfg_wdata = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [OUT_W-1:0]  m_axis_tdata;

    // Shadow machine state, advanced on every accepted instruction beat.
    logic [31:0] gpr [NUM_REGS];
    logic [15:0] ret_stack [STACK_DEPTH];
    logic [2:0]  cmp_code;
    int          call_depth;
    logic [15:0] vm_pc;
    logic [15:0] prog_end;

    logic [31:0] instr_fifo [$];
    t_vm_result  pending_results [$];
    int          beats_sent = 0;
    int          beats_in = 0;
    int          errors = 0;
    int          cyc = 0;
    logic        in_taken = 1'b0;
    logic        steady_run;

    assign steady_run = (cyc >= 600) && (cyc < 1300);

    toy_vm_instruction_executor_unit u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic bit cond_hits(input logic [2:0] cc, input logic [2:0] code);
        if (cc == CC_NONE) return 1'b0;
        if (cc == code) return 1'b1;
        if (cc == CC_LE && (code == CC_EQ || code == CC_LT)) return 1'b1;
        if (cc == CC_GE && (code == CC_EQ || code == CC_GT)) return 1'b1;
        return 1'b0;
    endfunction

    function automatic logic [31:0] reg_value(input logic [9:0] idx);
        return (idx < NUM_REGS) ? gpr[idx[3:0]] : 32'd0;
    endfunction

    function automatic t_vm_result execute_word(input logic [31:0] word);
        t_vm_result         res;
        logic [4:0]         fn;
        logic [2:0]         cc;
        t_mode              md;
        logic [21:0]        fld;
        logic [9:0]         a_idx;
        logic [9:0]         b_idx;
        logic [31:0]        a_val;
        logic [31:0]        b_val;
        logic [31:0]        sum;
        logic signed [31:0] lhs;
        logic signed [31:0] rhs;
        fn    = word[4:0];
        cc    = word[7:5];
        md    = t_mode'(word[9:8]);
        fld   = word[31:10];
        a_idx = fld[9:0];
        b_idx = fld[20:11];
        res   = '0;
        if (vm_pc >= prog_end) begin
            res.status = ST_SKIP;
        end else if (fn <= OP_CMP && fn != OP_RET && cond_hits(cc, cmp_code)) begin
            vm_pc      = vm_pc + 16'd1;
            res.status = ST_SKIP;
        end else if (fn <= OP_SUB) begin
            b_val = (md == MODE_OP2IMM) ? {22'd0, b_idx} : reg_value(b_idx);
            a_val = reg_value(a_idx);
            if (fn == OP_MOV) begin
                sum = b_val;
            end else if (fn == OP_ADD) begin
                sum = a_val + b_val;
            end else begin
                sum = a_val - b_val;
            end
            if (a_idx < NUM_REGS) begin
                gpr[a_idx[3:0]] = sum;
                res.write_valid = 1'b1;
                res.write_index = a_idx[3:0];
                res.write_value = sum;
            end
            vm_pc = vm_pc + 16'd1;
        end else if (fn == OP_JMP || fn == OP_CAL) begin
            if (fn == OP_CAL && call_depth >= STACK_DEPTH) begin
                vm_pc      = vm_pc + 16'd1;
                res.status = ST_OVF;
            end else begin
                if (fn == OP_CAL) begin
                    ret_stack[4'(call_depth)] = vm_pc + 16'd1;
                    call_depth++;
                end
                vm_pc = (md == MODE_OP2IMM) ? vm_pc + fld[15:0] : vm_pc - fld[15:0];
            end
        end else if (fn == OP_RET) begin
            if (call_depth == 0) begin
                vm_pc      = vm_pc + 16'd1;
                res.status = ST_SKIP;
            end else begin
                call_depth--;
                vm_pc = ret_stack[4'(call_depth)];
            end
        end else if (fn == OP_CMP) begin
            lhs = (md == MODE_OP1IMM) ? {22'd0, a_idx} : reg_value(a_idx);
            rhs = (md == MODE_OP2IMM) ? {22'd0, b_idx} : reg_value(b_idx);
            if (lhs == rhs) begin
                cmp_code = CC_EQ;
            end else if (lhs < rhs) begin
                cmp_code = CC_LT;
            end else begin
                cmp_code = CC_GT;
            end
            vm_pc = vm_pc + 16'd1;
        end else begin
            vm_pc      = vm_pc + 16'd1;
            res.status = ST_BAD;
        end
        res.next_pc      = vm_pc;
        res.compare_code = cmp_code;
        res.halted       = (vm_pc >= prog_end);
        return res;
    endfunction

    function automatic logic [31:0] pack_word(input logic [4:0] fn, input t_cc cc,
                                              input t_mode md, input logic [21:0] fld);
        return {fld, md, cc, fn};
    endfunction

    function automatic logic [21:0] reg_pair(input logic [9:0] a_idx, input logic [9:0] b_idx);
        return {1'b0, b_idx, 1'b0, a_idx};
    endfunction

    // Most jumps are short so the counter stays near the loaded code.
    function automatic logic [31:0] random_word();
        int          pick;
        logic [4:0]  fn;
        logic [2:0]  cc;
        logic [1:0]  md;
        logic [9:0]  a_idx;
        logic [9:0]  b_idx;
        logic [21:0] fld;
        pick = $urandom_range(99);
        if (pick < 14) begin
            fn = OP_MOV;
        end else if (pick < 27) begin
            fn = OP_ADD;
        end else if (pick < 37) begin
            fn = OP_SUB;
        end else if (pick < 45) begin
            fn = OP_JMP;
        end else if (pick < 58) begin
            fn = OP_CAL;
        end else if (pick < 68) begin
            fn = OP_RET;
        end else if (pick < 93) begin
            fn = OP_CMP;
        end else begin
            fn = 5'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
        end
        cc    = ($urandom_range(1) == 0) ? 3'(CC_NONE) : 3'($urandom_range(7, 1));
        md    = 2'($urandom_range(3));
        a_idx = ($urandom_range(9) == 0) ? 10'($urandom) : 10'($urandom_range(15));
        b_idx = (md == MODE_OP2IMM || $urandom_range(9) == 0) ?
                10'($urandom) : 10'($urandom_range(15));
        fld   = {1'($urandom), b_idx, 1'($urandom), a_idx};
        if (fn == OP_JMP || fn == OP_CAL) begin
            if ($urandom_range(9) != 0) begin
                fld = 22'($urandom_range(12));
                md  = ($urandom_range(9) < 6) ? 2'(MODE_OP2IMM) : 2'($urandom_range(3));
            end else begin
                fld = 22'($urandom);
            end
        end
        return {fld, md, cc, fn};
    endfunction

    task automatic queue_word(input logic [31:0] word);
        instr_fifo.push_back(word);
        beats_sent++;
    endtask

    task automatic queue_random(input int count);
        for (int i = 0; i < count; i++) begin
            queue_word(random_word());
        end
    endtask

    task automatic wait_idle();
        while (beats_in != beats_sent || pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_program_end(input logic [15:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        prog_end = value;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        errors++;
        $display("mismatch on %s: expected %0h, got %0h (cycle %0d)", what, want, got, cyc);
    endtask

    task automatic check_beat(input logic [OUT_W-1:0] beat);
        t_vm_result want;
        if (pending_results.size() == 0) begin
            report_mismatch("unexpected result beat", 32'd0, beat[31:0]);
        end else begin
            want = pending_results.pop_front();
            if (beat[15:0] !== want.next_pc)
                report_mismatch("next_pc", 32'(want.next_pc), 32'(beat[15:0]));
            if (beat[17:16] !== want.status)
                report_mismatch("status", 32'(want.status), 32'(beat[17:16]));
            if (beat[20:18] !== want.compare_code)
                report_mismatch("compare_code", 32'(want.compare_code), 32'(beat[20:18]));
            if (beat[21] !== want.write_valid)
                report_mismatch("write_valid", 32'(want.write_valid), 32'(beat[21]));
            if (beat[25:22] !== want.write_index)
                report_mismatch("write_index", 32'(want.write_index), 32'(beat[25:22]));
            if (beat[57:26] !== want.write_value)
                report_mismatch("write_value", want.write_value, beat[57:26]);
            if (beat[58] !== want.halted)
                report_mismatch("halted", 32'(want.halted), 32'(beat[58]));
        end
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || in_taken) begin
            if (instr_fifo.size() != 0 && (steady_run || $urandom_range(99) >= 16)) begin
                s_axis_tdata  <= instr_fifo.pop_front();
                s_axis_tvalid <= 1'b1;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= steady_run || ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        cyc <= cyc + 1;
        if (cyc >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
                check_beat(m_axis_tdata);
            end
            if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
                pending_results.push_back(execute_word(s_axis_tdata));
                beats_in++;
            end
            in_taken <= i_rst_n && s_axis_tvalid && s_axis_tready;
        end
    end

    initial begin
        int end_val;
        for (int i = 0; i < NUM_REGS; i++) begin
            gpr[4'(i)] = '0;
        end
        cmp_code   = CC_NONE;
        call_depth = 0;
        vm_pc      = 16'd1;
        prog_end   = 16'hFFFF;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        write_program_end(16'hFFFF);
        queue_word(pack_word(OP_MOV, CC_NONE, MODE_OP2IMM, reg_pair(10'd0, 10'd1023)));
        queue_word(pack_word(OP_MOV, CC_NONE, MODE_OP2IMM, reg_pair(10'd1, 10'd0)));
        queue_word(pack_word(OP_SUB, CC_NONE, MODE_REG, reg_pair(10'd2, 10'd0)));
        queue_word(pack_word(OP_ADD, CC_NONE, MODE_OP2IMM, reg_pair(10'd3, 10'd1023)));
        queue_word(pack_word(OP_MOV, CC_NONE, MODE_REG, reg_pair(10'd15, 10'd2)));
        queue_word(pack_word(OP_ADD, CC_NONE, MODE_BOTH, reg_pair(10'd4, 10'd15)));
        queue_word(pack_word(OP_MOV, CC_NONE, MODE_OP2IMM, reg_pair(10'd1023, 10'd5)));
        queue_word(pack_word(OP_ADD, CC_NONE, MODE_REG, reg_pair(10'd5, 10'd1023)));
        queue_word(pack_word(OP_CMP, CC_NONE, MODE_REG, reg_pair(10'd2, 10'd0)));
        queue_word(pack_word(OP_MOV, CC_LT, MODE_OP2IMM, reg_pair(10'd6, 10'd7)));
        queue_word(pack_word(OP_ADD, CC_LE, MODE_REG, reg_pair(10'd6, 10'd0)));
        queue_word(pack_word(OP_SUB, CC_GE, MODE_REG, reg_pair(10'd6, 10'd0)));
        queue_word(pack_word(OP_CMP, CC_NONE, MODE_OP1IMM, reg_pair(10'd1023, 10'd0)));
        queue_word(pack_word(OP_JMP, CC_EQ, MODE_OP2IMM, 22'd9));
        queue_word(pack_word(OP_CMP, CC_NONE, MODE_OP2IMM, reg_pair(10'd0, 10'd0)));
        queue_word(pack_word(OP_JMP, CC_GE, MODE_OP2IMM, 22'd9));
        queue_word(pack_word(OP_JMP, CC_NONE, MODE_OP2IMM, 22'd4));
        queue_word(pack_word(OP_JMP, CC_NONE, MODE_REG, 22'd2));
        queue_word(pack_word(OP_JMP, CC_NONE, MODE_BOTH, 22'd1));
        queue_word(pack_word(OP_RET, CC_NONE, MODE_REG, 22'd0));
        queue_word(pack_word(OP_CAL, CC_NONE, MODE_OP2IMM, 22'd3));
        queue_word(pack_word(OP_RET, CC_GT, MODE_REG, 22'd0));
        queue_word(pack_word(OP_UNKNOWN_HI, CC_NONE, MODE_REG, 22'h3FFFFF));
        queue_word(pack_word(OP_UNKNOWN_LO, CC_NONE, MODE_REG, 22'd0));
        queue_word(pack_word(OP_CMP, t_cc'(3'd7), MODE_REG, reg_pair(10'd0, 10'd0)));
        queue_word(pack_word(OP_JMP, CC_NONE, MODE_OP2IMM, 22'h3FFFFF));
        wait_idle();

        queue_random(650);
        wait_idle();

        // Place the end of code just ahead of the counter so the machine halts.
        end_val = int'(vm_pc) + $urandom_range(80, 20);
        write_program_end((end_val > 65535) ? 16'hFFFF : 16'(end_val));
        queue_random(300);
        wait_idle();

        write_program_end(16'd1);
        queue_random(20);
        wait_idle();

        write_program_end(16'hFFFF);
        queue_random(500);
        wait_idle();

        write_program_end(16'($urandom_range(65535, 1)));
        queue_random(280);
        wait_idle();

        if (errors == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
